### hdl/idq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idq_pkg
// shared types, widths and helpers for the indexed deque
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int CAPACITY  = 256;
  localparam int ITEM_BITS = 64;

  // fixed port widths
  localparam int KIND_W    = 2;
  localparam int DATA_W    = 64;
  localparam int POS_W     = 8;
  localparam int OUT_CNT_W = 9;

  // derived storage widths
  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 2'd0,
    KIND_PUSH_FRONT = 2'd1,
    KIND_POP_BACK   = 2'd2,
    KIND_READ       = 2'd3
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // take the input word and run it against the store
  } dp_cmd_t;

  // front pointer plus offset, wrapped into the circular store
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] front,
                                               input logic [PTR_W-1:0] offset);
    logic [PTR_W:0] sum;
    sum = {1'b0, front} + {1'b0, offset};
    if (sum >= (PTR_W+1)'(CAPACITY)) begin
      sum = sum - (PTR_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hdl/idq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idq_ctrl
// handshake controller: loads a request and holds its result until taken
// ----------------------------------------------------------------------------
module idq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output idq_pkg::dp_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // a waiting result leaves in the same cycle a new word comes in
  assign in_ready  = (state_r == ST_IDLE) || out_ready;
  assign out_valid = (state_r == ST_RESP);
  assign cmd.load  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready && !in_valid) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid)
    else $error("loaded request produced no result");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  a_no_load_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !cmd.load)
    else $error("request loaded over a waiting result");
`endif

endmodule
`default_nettype wire

### hdl/idq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idq_dp
// deque datapath: front pointer, count, circular store and result register
// ----------------------------------------------------------------------------
module idq_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire idq_pkg::dp_cmd_t                 cmd,
  input  wire logic [idq_pkg::KIND_W-1:0]       in_kind,
  input  wire logic [idq_pkg::DATA_W-1:0]       in_entry_data,
  input  wire logic [idq_pkg::POS_W-1:0]        in_position,
  output logic                                  out_ok,
  output logic [idq_pkg::DATA_W-1:0]            out_data,
  output logic [idq_pkg::OUT_CNT_W-1:0]         out_count,
  output logic                                  out_is_empty
);

  logic [idq_pkg::ITEM_BITS-1:0] mem [idq_pkg::CAPACITY];

  logic [idq_pkg::PTR_W-1:0]     front_r, front_nxt;
  logic [idq_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                          ok_r, ok_nxt;
  logic                          rd_r, rd_nxt;
  logic [idq_pkg::ITEM_BITS-1:0] rd_data_r;

  idq_pkg::kind_t                kind;
  logic                          full, empty, pos_hit;
  logic                          wr_en;
  logic [idq_pkg::PTR_W-1:0]     offset, slot;
  logic [idq_pkg::ITEM_BITS-1:0] wr_data;

  assign kind    = idq_pkg::kind_t'(in_kind);
  assign full    = (count_r == idq_pkg::CNT_W'(idq_pkg::CAPACITY));
  assign empty   = (count_r == '0);
  assign pos_hit = (idq_pkg::CMP_W'(in_position) < idq_pkg::CMP_W'(count_r));
  assign wr_data = idq_pkg::ITEM_BITS'(in_entry_data);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    rd_nxt    = 1'b0;
    wr_en     = 1'b0;
    offset    = '0;
    unique case (kind)
      idq_pkg::KIND_PUSH_BACK: begin
        offset = idq_pkg::PTR_W'(count_r);
        if (!full) begin
          ok_nxt    = 1'b1;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      idq_pkg::KIND_PUSH_FRONT: begin
        offset = idq_pkg::PTR_W'(idq_pkg::CAPACITY - 1);
        if (!full) begin
          ok_nxt    = 1'b1;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      idq_pkg::KIND_POP_BACK: begin
        offset = idq_pkg::PTR_W'(count_r - 1'b1);
        rd_nxt = 1'b1;
        if (!empty) begin
          ok_nxt    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      idq_pkg::KIND_READ: begin
        offset = idq_pkg::PTR_W'(in_position);
        rd_nxt = 1'b1;
        ok_nxt = pos_hit;
      end
      default: ;
    endcase
    slot = idq_pkg::slot_of(front_r, offset);
    // the new front slot is exactly the slot written by a push front
    if (kind == idq_pkg::KIND_PUSH_FRONT && !full) front_nxt = slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      ok_r    <= 1'b0;
      rd_r    <= 1'b0;
    end else if (cmd.load) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      ok_r    <= ok_nxt;
      rd_r    <= rd_nxt;
    end
  end

  // circular store: a write on a push, a registered read on every request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (wr_en) mem[slot] <= wr_data;
      rd_data_r <= mem[slot];
    end
  end

  assign out_ok       = ok_r;
  assign out_data     = (ok_r && rd_r) ? idq_pkg::DATA_W'(rd_data_r) : '0;
  assign out_count    = idq_pkg::OUT_CNT_W'(count_r);
  assign out_is_empty = (count_r == '0);

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= idq_pkg::CNT_W'(idq_pkg::CAPACITY))
    else $error("entry count past capacity");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.load |=> ($stable(count_r) && $stable(front_r)))
    else $error("deque state moved without a request");

  a_front_moves_on_push_front: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !(kind == idq_pkg::KIND_PUSH_FRONT && !full)) |=> $stable(front_r))
    else $error("front pointer moved on a request other than push front");
`endif

endmodule
`default_nettype wire

### hdl/indexed_deque.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_deque
// bounded double-ended queue in a circular store, with indexed reads
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in_      | input     | in_valid / in_ready   | kind, entry_data, position
//  out_     | output    | out_valid / out_ready | ok, data, count, is_empty
//
//  one request per cycle unless a result stalls; its result shows the next cycle
//  the store is one memory: a write on a push, a registered read on every request
//  in_ready stays high while the result register is empty or being taken
//  a stalled result blocks new requests; nothing is lost or reordered
//  synchronous reset clears pointer and count; store contents are not cleared
// ----------------------------------------------------------------------------
module indexed_deque (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [idq_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [idq_pkg::DATA_W-1:0]    in_entry_data,
  input  wire logic [idq_pkg::POS_W-1:0]     in_position,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_ok,
  output logic [idq_pkg::DATA_W-1:0]         out_data,
  output logic [idq_pkg::OUT_CNT_W-1:0]      out_count,
  output logic                               out_is_empty
);

  idq_pkg::dp_cmd_t cmd;

  idq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  idq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_kind       (in_kind),
    .in_entry_data (in_entry_data),
    .in_position   (in_position),
    .out_ok        (out_ok),
    .out_data      (out_data),
    .out_count     (out_count),
    .out_is_empty  (out_is_empty)
  );

endmodule
`default_nettype wire

### bench/tb_indexed_deque.sv
// ----------------------------------------------------------------------------
// tb_indexed_deque
// self-checking bench for the indexed deque: a directed table walks the empty,
// single and wrap cases, then a fill-to-full and drain run, then random phases
// of push, pop and read words. Every accepted request is run through a local
// model of the deque, and each result word is compared field by field.
// ----------------------------------------------------------------------------
module tb_indexed_deque;

  localparam int                         DEPTH       = idq_pkg::CAPACITY;
  localparam int                         ITEM_TARGET = 1400;
  localparam logic [idq_pkg::DATA_W-1:0] ONES        = {idq_pkg::DATA_W{1'b1}};
  localparam logic [idq_pkg::DATA_W-1:0] ITEM_MASK   =
    ONES >> (idq_pkg::DATA_W - idq_pkg::ITEM_BITS);

  typedef struct packed {
    logic                          ok;
    logic [idq_pkg::DATA_W-1:0]    data;
    logic [idq_pkg::OUT_CNT_W-1:0] count;
    logic                          empty;
  } deque_result_t;

  typedef struct packed {
    idq_pkg::kind_t             kind;
    logic [idq_pkg::DATA_W-1:0] data;
    logic [idq_pkg::POS_W-1:0]  pos;
    logic                       typed;
    deque_result_t              res;
  } request_row_t;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } phase_mode_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [idq_pkg::KIND_W-1:0]    in_kind = '0;
  logic [idq_pkg::DATA_W-1:0]    in_entry_data = '0;
  logic [idq_pkg::POS_W-1:0]     in_position = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_ok;
  logic [idq_pkg::DATA_W-1:0]    out_data;
  logic [idq_pkg::OUT_CNT_W-1:0] out_count;
  logic                          out_is_empty;

  // local copy of the deque
  logic [idq_pkg::DATA_W-1:0] dq_store [DEPTH];
  int                         dq_front = 0;
  int                         dq_count = 0;

  deque_result_t pending_results [$];
  int            mismatches    = 0;
  int            words_sent    = 0;
  int            words_checked = 0;

  // typed rows carry the result that can be read straight off the request
  request_row_t directed_rows [22] = '{
    '{idq_pkg::KIND_POP_BACK,   64'h0, 8'h00, 1'b1, '{1'b0, 64'h0, 9'd0, 1'b1}},
    '{idq_pkg::KIND_READ,       64'h0, 8'h00, 1'b1, '{1'b0, 64'h0, 9'd0, 1'b1}},
    '{idq_pkg::KIND_READ,       ONES,  8'hff, 1'b1, '{1'b0, 64'h0, 9'd0, 1'b1}},
    '{idq_pkg::KIND_PUSH_BACK,  ONES,  8'h00, 1'b1, '{1'b1, 64'h0, 9'd1, 1'b0}},
    '{idq_pkg::KIND_PUSH_FRONT, 64'h0, 8'hff, 1'b1, '{1'b1, 64'h0, 9'd2, 1'b0}},
    '{idq_pkg::KIND_READ,       64'h0, 8'h00, 1'b1, '{1'b1, 64'h0, 9'd2, 1'b0}},
    '{idq_pkg::KIND_READ,       64'h0, 8'h01, 1'b1, '{1'b1, ONES,  9'd2, 1'b0}},
    '{idq_pkg::KIND_READ,       64'h0, 8'h02, 1'b1, '{1'b0, 64'h0, 9'd2, 1'b0}},
    '{idq_pkg::KIND_READ,       64'h0, 8'hff, 1'b1, '{1'b0, 64'h0, 9'd2, 1'b0}},
    '{idq_pkg::KIND_PUSH_FRONT, 64'h8000_0000_0000_0001, 8'h00, 1'b0, '0},
    '{idq_pkg::KIND_PUSH_BACK,  64'ha5a5_5a5a_c3c3_3c3c, 8'h00, 1'b0, '0},
    '{idq_pkg::KIND_READ,       64'h0, 8'h03, 1'b0, '0},
    '{idq_pkg::KIND_READ,       64'h0, 8'h04, 1'b0, '0},
    '{idq_pkg::KIND_READ,       64'h0, 8'h80, 1'b0, '0},
    '{idq_pkg::KIND_POP_BACK,   64'h0, 8'h00, 1'b0, '0},
    '{idq_pkg::KIND_POP_BACK,   64'h0, 8'h00, 1'b0, '0},
    '{idq_pkg::KIND_POP_BACK,   64'h0, 8'h00, 1'b0, '0},
    '{idq_pkg::KIND_POP_BACK,   64'h0, 8'h00, 1'b0, '0},
    '{idq_pkg::KIND_POP_BACK,   64'h0, 8'h00, 1'b1, '{1'b0, 64'h0, 9'd0, 1'b1}},
    '{idq_pkg::KIND_PUSH_BACK,  64'h0123_4567_89ab_cdef, 8'hff, 1'b0, '0},
    '{idq_pkg::KIND_READ,       ONES,  8'h00, 1'b0, '0},
    '{idq_pkg::KIND_POP_BACK,   64'h0, 8'h00, 1'b0, '0}
  };

  indexed_deque dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_entry_data(in_entry_data),
    .in_position  (in_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ok       (out_ok),
    .out_data     (out_data),
    .out_count    (out_count),
    .out_is_empty (out_is_empty)
  );

  always #1 clk = ~clk;

  // apply one request to the local deque and return its result word
  function automatic deque_result_t deque_apply(input idq_pkg::kind_t k,
                                                input logic [idq_pkg::DATA_W-1:0] d,
                                                input logic [idq_pkg::POS_W-1:0] p);
    deque_result_t r;
    r = '0;
    case (k)
      idq_pkg::KIND_PUSH_BACK: begin
        if (dq_count < DEPTH) begin
          dq_store[(dq_front + dq_count) % DEPTH] = d & ITEM_MASK;
          dq_count++;
          r.ok = 1'b1;
        end
      end
      idq_pkg::KIND_PUSH_FRONT: begin
        if (dq_count < DEPTH) begin
          dq_front = (dq_front + DEPTH - 1) % DEPTH;
          dq_store[dq_front] = d & ITEM_MASK;
          dq_count++;
          r.ok = 1'b1;
        end
      end
      idq_pkg::KIND_POP_BACK: begin
        if (dq_count > 0) begin
          r.data = dq_store[(dq_front + dq_count - 1) % DEPTH];
          dq_count--;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (int'(p) < dq_count) begin
          r.data = dq_store[(dq_front + int'(p)) % DEPTH];
          r.ok = 1'b1;
        end
      end
    endcase
    r.data  = r.data & ITEM_MASK;
    r.count = idq_pkg::OUT_CNT_W'(dq_count);
    r.empty = (dq_count == 0);
    return r;
  endfunction

  // mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [idq_pkg::DATA_W-1:0] random_data();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return ONES;
    if (r == 1) return '0;
    return {$urandom(), $urandom()};
  endfunction

  // reads mostly land inside the queue, the rest anywhere
  function automatic logic [idq_pkg::POS_W-1:0] random_position();
    if (dq_count > 0 && $urandom_range(0, 4) != 0)
      return idq_pkg::POS_W'($urandom_range(0, dq_count - 1));
    return idq_pkg::POS_W'($urandom());
  endfunction

  function automatic idq_pkg::kind_t random_push();
    return ($urandom_range(0, 1) == 0) ? idq_pkg::KIND_PUSH_BACK : idq_pkg::KIND_PUSH_FRONT;
  endfunction

  function automatic idq_pkg::kind_t random_kind(input phase_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:
        return (r < 70) ? random_push() :
               (r < 85) ? idq_pkg::KIND_READ : idq_pkg::KIND_POP_BACK;
      MODE_DRAIN:
        return (r < 70) ? idq_pkg::KIND_POP_BACK :
               (r < 85) ? idq_pkg::KIND_READ : random_push();
      default: begin
        if (r < 30) return idq_pkg::KIND_PUSH_BACK;
        if (r < 50) return idq_pkg::KIND_PUSH_FRONT;
        if (r < 70) return idq_pkg::KIND_POP_BACK;
        return idq_pkg::KIND_READ;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [idq_pkg::DATA_W-1:0] want,
                               input logic [idq_pkg::DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at word %0d: %s expected %h got %h", words_checked, what, want, got);
  endtask

  // hold the word until accepted, then predict and leave an optional gap
  task automatic send_word(input idq_pkg::kind_t k, input logic [idq_pkg::DATA_W-1:0] d,
                           input logic [idq_pkg::POS_W-1:0] p, input logic typed,
                           input deque_result_t typed_res, input bit calm);
    deque_result_t res;
    int gap;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_entry_data <= d;
    in_position   <= p;
    do @(posedge clk); while (!in_ready);
    res = deque_apply(k, d, p);
    pending_results.push_back(typed ? typed_res : res);
    words_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_random(input idq_pkg::kind_t k, input bit calm);
    send_word(k, random_data(), random_position(), 1'b0, '0, calm);
  endtask

  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok)
          flag_mismatch("ok", idq_pkg::DATA_W'(want.ok), idq_pkg::DATA_W'(out_ok));
        if (out_data !== want.data)
          flag_mismatch("data", want.data, out_data);
        if (out_count !== want.count)
          flag_mismatch("count", idq_pkg::DATA_W'(want.count), idq_pkg::DATA_W'(out_count));
        if (out_is_empty !== want.empty)
          flag_mismatch("is_empty", idq_pkg::DATA_W'(want.empty),
                        idq_pkg::DATA_W'(out_is_empty));
      end
      words_checked++;
    end
  end

  initial begin : result_sink
    int  stall_left;
    int  seen;
    int  holds_done;
    bit  calm;
    stall_left = 0;
    seen       = 0;
    holds_done = 0;
    calm       = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (words_checked != seen) begin
        seen = words_checked;
        if (seen % 100 == 0) calm = ($urandom_range(0, 2) == 0);
        // long hold-off so the result register backs up into the input
        if (holds_done < 2 && seen >= ((holds_done == 0) ? 250 : 1000)) begin
          stall_left = 150;
          holds_done++;
        end else begin
          stall_left = calm ? 0 : pick_gap();
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : request_source
    phase_mode_t mode;
    int          phase_len;
    bit          calm;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_word(directed_rows[i].kind, directed_rows[i].data, directed_rows[i].pos,
                directed_rows[i].typed, directed_rows[i].res, 1'b0);

    // fill to the top, push against full, then drain past empty
    while (dq_count < DEPTH)
      send_random(($urandom_range(0, 7) == 0) ? idq_pkg::KIND_READ : random_push(), 1'b0);
    repeat (6) send_random(random_push(), 1'b0);
    send_word(idq_pkg::KIND_READ, '0, 8'hff, 1'b0, '0, 1'b0);
    send_word(idq_pkg::KIND_READ, '0, 8'h00, 1'b0, '0, 1'b0);
    while (dq_count > 0)
      send_random(($urandom_range(0, 7) == 0) ? idq_pkg::KIND_READ : idq_pkg::KIND_POP_BACK,
                  1'b0);
    repeat (3) send_random(idq_pkg::KIND_POP_BACK, 1'b0);

    while (words_sent < ITEM_TARGET) begin
      mode      = phase_mode_t'($urandom_range(0, 2));
      phase_len = $urandom_range(30, 150);
      calm      = ($urandom_range(0, 3) == 0);
      repeat (phase_len) send_random(random_kind(mode), calm);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin : run_limit
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
hdl/idq_pkg.sv
hdl/idq_ctrl.sv
hdl/idq_dp.sv
hdl/indexed_deque.sv
bench/tb_indexed_deque.sv
